// File: rtl/wsr_pkg.sv
// Shared types and constants for the LED strip refresher.
// Used by wsr_regs, wsr_ctrl, wsr_dp and the top level; no dependencies.
package wsr_pkg;

	localparam int LED_COUNT_DEF = 60;
	localparam int APB_AW        = 4;
	localparam logic [7:0] INTENSITY_RST = 8'h0F;

	// command codes carried in s_tuser
	localparam logic [1:0] MODE_SET     = 2'd0;
	localparam logic [1:0] MODE_FILL    = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;
	localparam logic [1:0] MODE_REFRESH = 2'd3;

	// color mask bits
	localparam logic [2:0] EN_BLUE  = 3'b001;
	localparam logic [2:0] EN_GREEN = 3'b010;
	localparam logic [2:0] EN_RED   = 3'b100;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_RED   = 2'd0;
	localparam logic [1:0] REG_GREEN = 2'd1;
	localparam logic [1:0] REG_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} intensity_t;

	typedef struct packed {
		logic set_wr;     // write one entry from the input word
		logic clr_all;    // drop every valid bit
		logic fill_start; // latch fill mask, counter to zero
		logic fill_wr;    // write entry at counter, count up
		logic rfr_start;  // counter to top entry
		logic rd;         // read entry at counter
		logic out_load;   // build output word
		logic cnt_dn;     // step to next lower entry
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_top;
	} sts_t;

endpackage

// File: rtl/wsr_regs.sv
// APB register file for the red, green and blue intensity bytes.
// Depends on wsr_pkg.
module wsr_regs
	import wsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output intensity_t        intensity
);

	intensity_t int_q;
	logic       wr_en;

	assign pready    = 1'b1;
	assign wr_en     = psel & penable & pwrite;
	assign intensity = int_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q.red   <= INTENSITY_RST;
			int_q.green <= INTENSITY_RST;
			int_q.blue  <= INTENSITY_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_RED:   int_q.red   <= pwdata[7:0];
				REG_GREEN: int_q.green <= pwdata[7:0];
				REG_BLUE:  int_q.blue  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_RED:   prdata = {24'd0, int_q.red};
			REG_GREEN: prdata = {24'd0, int_q.green};
			REG_BLUE:  prdata = {24'd0, int_q.blue};
			default:   prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/wsr_ctrl.sv
// Command sequencer: decodes commands and steps fill and refresh sweeps.
// Depends on wsr_pkg; drives wsr_dp through cmd_t and reads sts_t.
module wsr_ctrl
	import wsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] s_tuser,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_FILL = 5'b00010,
		S_RD   = 5'b00100,
		S_LOAD = 5'b01000,
		S_SEND = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_SEND);
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						MODE_SET:   cmd.set_wr = 1'b1;
						MODE_CLEAR: cmd.clr_all = 1'b1;
						MODE_FILL: begin
							cmd.fill_start = 1'b1;
							state_d        = S_FILL;
						end
						default: begin
							cmd.rfr_start = 1'b1;
							state_d       = S_RD;
						end
					endcase
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.cnt_top)
					state_d = S_IDLE;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = S_SEND;
			end
			S_SEND: begin
				// hold the word until taken; lowest entry ends the sweep
				if (m_tready) begin
					if (sts.cnt_zero) begin
						state_d = S_IDLE;
					end else begin
						cmd.cnt_dn = 1'b1;
						state_d    = S_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: rtl/wsr_dp.sv
// Datapath: color mask memory with per-entry valid bits, sweep counter
// and output word register. Depends on wsr_pkg; commanded by wsr_ctrl.
module wsr_dp
	import wsr_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [5:0]  led_index,
	input  logic [2:0]  color_mask,
	input  intensity_t  intensity,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic [23:0] grb_word,
	output logic        last_word
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam logic [IDX_W-1:0] TOP = IDX_W'(LED_COUNT - 1);

	logic [2:0]           mask_mem_q [LED_COUNT];
	logic [LED_COUNT-1:0] vld_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [2:0]           fill_mask_q;
	logic [2:0]           rd_mask_q;
	logic                 rd_vld_q;
	logic [23:0]          word_q;
	logic                 last_q;

	logic             set_ok;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [2:0]       mem_wd;
	logic [2:0]       eff_mask;

	assign set_ok = ({1'b0, led_index} < 7'(LED_COUNT));
	assign mem_we = (cmd.set_wr & set_ok) | cmd.fill_wr;
	assign mem_wa = cmd.fill_wr ? cnt_q : led_index[IDX_W-1:0];
	assign mem_wd = cmd.fill_wr ? fill_mask_q : color_mask;

	always_ff @(posedge clk) begin
		if (mem_we)
			mask_mem_q[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd)
			rd_mask_q <= mask_mem_q[cnt_q];
	end

	// an entry never written since reset or clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_all)
				vld_q <= '0;
			else if (mem_we)
				vld_q[mem_wa] <= 1'b1;
			if (cmd.rd)
				rd_vld_q <= vld_q[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (cmd.fill_start)
			cnt_q <= '0;
		else if (cmd.rfr_start)
			cnt_q <= TOP;
		else if (cmd.fill_wr)
			cnt_q <= (cnt_q == TOP) ? '0 : cnt_q + 1'b1;
		else if (cmd.cnt_dn)
			cnt_q <= cnt_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_start)
			fill_mask_q <= color_mask;
	end

	assign eff_mask = rd_vld_q ? rd_mask_q : 3'b000;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			word_q[23:16] <= |(eff_mask & EN_GREEN) ? intensity.green : 8'd0;
			word_q[15:8]  <= |(eff_mask & EN_RED)   ? intensity.red   : 8'd0;
			word_q[7:0]   <= |(eff_mask & EN_BLUE)  ? intensity.blue  : 8'd0;
			last_q        <= (cnt_q == '0);
		end
	end

	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_top  = (cnt_q == TOP);
	assign grb_word     = word_q;
	assign last_word    = last_q;

endmodule

// File: rtl/ws2812_color_strip_refresher.sv
// Top level of the LED strip refresher: APB registers, sequencer, datapath.
// Depends on wsr_pkg, wsr_regs, wsr_ctrl and wsr_dp.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------
//  s_*      | in  | s_tvalid / s_tready     | tuser: mode; tdata: index, mask
//  m_*      | out | m_tvalid / m_tready     | tdata: grb word; tlast: last
//  apb      | in  | psel & penable, pready  | intensity registers 0x0..0x8
//
// Set and clear finish in the idle state when accepted; fill makes one memory
// write per entry in the fill state. Refresh takes each word through a
// registered memory read, a word build and a send state that waits for m_tready.
// Reset clears all valid bits at once, so no clearing pass is needed.
// A stalled output holds the word and the sweep; no command is taken until done.
module ws2812_color_strip_refresher
	import wsr_pkg::*;
#(
	parameter int LED_COUNT = LED_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // led_index[5:0], color_mask[8:6], zero pad
	input  logic [1:0]        s_tuser,   // mode[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // grb_word[23:0]
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	intensity_t intensity;
	cmd_t       cmd;
	sts_t       sts;

	wsr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.intensity (intensity)
	);

	wsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wsr_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.led_index  (s_tdata[5:0]),
		.color_mask (s_tdata[8:6]),
		.intensity  (intensity),
		.cmd        (cmd),
		.sts        (sts),
		.grb_word   (m_tdata),
		.last_word  (m_tlast)
	);

endmodule
